>>> rtl/ngga_pkg.sv
// shared constants, types and helper functions for the gga position parser
// no dependencies; imported by ngga_coord and nmea_gga_position_parser
package ngga_pkg;

  // number formats
  localparam int MINUTE_FRAC_DIGITS = 5;
  localparam int UTC_FRAC_DIGITS    = 3;

  // pipeline depth from snapshot to output register
  localparam int NUM_STG = 7;

  // field widths
  localparam int UTC_W   = 30;
  localparam int COORD_W = 35;
  localparam int WHOLE_W = 17;
  localparam int FRAC_W  = $clog2(10 ** MINUTE_FRAC_DIGITS);
  localparam int FCNT_W  = $clog2(MINUTE_FRAC_DIGITS + 1);
  localparam int UFD_W   = 2;
  localparam int ICNT_W  = 2;
  localparam int USCL_W  = 10;
  localparam int HDR_LEN = 6;

  localparam logic [UTC_W-1:0]   UTC_MAX   = 30'd999999999;
  localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd100099;
  localparam logic [ICNT_W-1:0]  ICNT_FULL = 2'd3;

  // characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;

  // field positions within the sentence
  localparam logic [3:0] FIELD_HDR     = 4'd0;
  localparam logic [3:0] FIELD_UTC     = 4'd1;
  localparam logic [3:0] FIELD_LAT     = 4'd2;
  localparam logic [3:0] FIELD_LAT_DIR = 4'd3;
  localparam logic [3:0] FIELD_LON     = 4'd4;
  localparam logic [3:0] FIELD_LON_DIR = 4'd5;
  localparam logic [3:0] FIELD_MAX     = 4'd15;

  // whole part split into degrees and minutes: x / 100 by reciprocal
  localparam int DEG_SHIFT   = 24;
  localparam int RECIP_DEG_W = 18;
  localparam logic [RECIP_DEG_W-1:0] DEG_RECIP =
    RECIP_DEG_W'(((64'd1 << DEG_SHIFT) + 64'd99) / 64'd100);
  localparam int DEG_W = 10;
  localparam int MW_W  = 7;

  // minutes to 1e-7 degree: scale up, then x / 60 by reciprocal
  localparam int MIN_W     = $clog2(10 ** (MINUTE_FRAC_DIGITS + 2));
  localparam int MIN_TO_E7 = 10 ** (7 - MINUTE_FRAC_DIGITS);
  localparam int X_W       = 30;
  localparam int DIV_SHIFT = 36;
  localparam int RECIP60_W = 31;
  localparam logic [RECIP60_W-1:0] RECIP60 =
    RECIP60_W'(((64'd1 << DIV_SHIFT) + 64'd59) / 64'd60);
  localparam int Q_W      = 24;
  localparam int DEG_E7_W = 34;
  localparam logic [DEG_E7_W-1:0] DEG_UNIT = 34'd10000000;
  localparam logic [MIN_W-1:0]    MIN_UNIT = MIN_W'(10 ** MINUTE_FRAC_DIGITS);

  // running state of one coordinate field
  typedef struct packed {
    logic               any;
    logic               dot;
    logic [ICNT_W-1:0]  icnt;
    logic [FCNT_W-1:0]  fcnt;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
  } coord_acc_t;

  // coordinate snapshot handed to the conversion pipeline
  typedef struct packed {
    logic               kill;
    logic               neg;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [FCNT_W-1:0]  fcnt;
  } coord_snap_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // expected header text, one character per position
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = CH_DOLLAR;
      3'd1:    r = CH_G;
      3'd2:    r = CH_P;
      3'd3:    r = CH_G;
      3'd4:    r = CH_G;
      3'd5:    r = CH_A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // 10^(MINUTE_FRAC_DIGITS - cnt) for missing fraction digits
  function automatic logic [FRAC_W-1:0] frac_scale(input logic [FCNT_W-1:0] cnt);
    logic [FRAC_W-1:0] p;
    p = FRAC_W'(1);
    for (int i = 0; i < MINUTE_FRAC_DIGITS; i++) begin
      if (FCNT_W'(i) >= cnt) p = FRAC_W'(p * 10);
    end
    return p;
  endfunction

  // 10^(UTC_FRAC_DIGITS - cnt) for missing utc fraction digits
  function automatic logic [USCL_W-1:0] utc_scale(input logic [UFD_W-1:0] cnt);
    logic [USCL_W-1:0] p;
    p = USCL_W'(1);
    for (int i = 0; i < UTC_FRAC_DIGITS; i++) begin
      if (UFD_W'(i) >= cnt) p = USCL_W'(p * 10);
    end
    return p;
  endfunction

  // one character of a coordinate field
  function automatic coord_acc_t coord_step(input coord_acc_t a, input logic [7:0] c);
    coord_acc_t r;
    logic [WHOLE_W+3:0] wv;
    r = a;
    r.any = 1'b1;
    wv = (WHOLE_W+4)'(a.whole) * (WHOLE_W+4)'(10) + (WHOLE_W+4)'(c[3:0]);
    if (is_digit(c)) begin
      if (!a.dot) begin
        r.whole = (wv > (WHOLE_W+4)'(WHOLE_MAX)) ? WHOLE_MAX : wv[WHOLE_W-1:0];
        if (a.icnt != ICNT_FULL) r.icnt = a.icnt + ICNT_W'(1);
      end else if (a.fcnt < FCNT_W'(MINUTE_FRAC_DIGITS)) begin
        r.frac = a.frac * FRAC_W'(10) + FRAC_W'(c[3:0]);
        r.fcnt = a.fcnt + FCNT_W'(1);
      end
    end else if ((c == CH_DOT) && !a.dot) begin
      r.dot = 1'b1;
    end
    return r;
  endfunction

  // character that cannot belong to a coordinate number
  function automatic logic coord_bad(input coord_acc_t a, input logic [7:0] c);
    return !is_digit(c) && !((c == CH_DOT) && !a.dot);
  endfunction

endpackage

>>> rtl/ngga_coord.sv
// conversion pipeline for one coordinate: ddmm.mmmmm text value to 1e-7 degrees
// depends on ngga_pkg; stage loads are driven by the top level flow control
module ngga_coord
  import ngga_pkg::*;
(
  input  logic                      clk,
  input  logic [NUM_STG-1:0]        en,
  input  coord_snap_t               snap,
  output logic signed [COORD_W-1:0] value
);

  coord_snap_t s0;

  logic                             kill1, neg1;
  logic [WHOLE_W-1:0]               whole1;
  logic [WHOLE_W+RECIP_DEG_W-1:0]   pdeg1;
  logic [FRAC_W-1:0]                fs1;

  logic                             kill2, neg2;
  logic [DEG_W-1:0]                 deg2;
  logic [MW_W-1:0]                  mw2;
  logic [FRAC_W-1:0]                fs2;

  logic                             kill3, neg3;
  logic [MIN_W-1:0]                 min3;
  logic [DEG_E7_W-1:0]              de3;

  logic                             kill4, neg4;
  logic [X_W-1:0]                   x4;
  logic [DEG_E7_W-1:0]              de4;

  logic                             kill5, neg5;
  logic [X_W+RECIP60_W-1:0]         qp5;
  logic [DEG_E7_W-1:0]              de5;

  logic [DEG_W-1:0]                 deg_c;
  logic [WHOLE_W-1:0]               diff_c;
  logic [Q_W-1:0]                   q_c;
  logic [COORD_W-1:0]               mag_c;

  // degree split and final sum
  always_comb begin
    deg_c  = pdeg1[DEG_SHIFT +: DEG_W];
    diff_c = whole1 - WHOLE_W'(deg_c) * WHOLE_W'(100);
    q_c    = qp5[DIV_SHIFT +: Q_W];
    mag_c  = COORD_W'(de5) + COORD_W'(q_c);
  end

  // snapshot, reciprocal products, then scaling and sign
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0 <= snap;
    end
    if (en[1]) begin
      kill1  <= s0.kill;
      neg1   <= s0.neg;
      whole1 <= s0.whole;
      pdeg1  <= (WHOLE_W+RECIP_DEG_W)'(s0.whole) * (WHOLE_W+RECIP_DEG_W)'(DEG_RECIP);
      fs1    <= s0.frac * frac_scale(s0.fcnt);
    end
    if (en[2]) begin
      kill2 <= kill1;
      neg2  <= neg1;
      deg2  <= deg_c;
      mw2   <= diff_c[MW_W-1:0];
      fs2   <= fs1;
    end
    if (en[3]) begin
      kill3 <= kill2;
      neg3  <= neg2;
      min3  <= MIN_W'(mw2) * MIN_UNIT + MIN_W'(fs2);
      de3   <= DEG_E7_W'(deg2) * DEG_UNIT;
    end
    if (en[4]) begin
      kill4 <= kill3;
      neg4  <= neg3;
      x4    <= X_W'(min3) * X_W'(MIN_TO_E7);
      de4   <= de3;
    end
    if (en[5]) begin
      kill5 <= kill4;
      neg5  <= neg4;
      qp5   <= (X_W+RECIP60_W)'(x4) * (X_W+RECIP60_W)'(RECIP60);
      de5   <= de4;
    end
    if (en[6]) begin
      if (kill5) begin
        value <= '0;
      end else if (neg5) begin
        value <= -$signed(mag_c);
      end else begin
        value <= $signed(mag_c);
      end
    end
  end

endmodule

>>> rtl/nmea_gga_position_parser.sv
// gga position parser: character stream in, one decoded position per sentence out
// slave channel carries one character per transaction, tlast marks the sentence end
// output channel carries utc, latitude, longitude and two status flags
// the block takes one character per clock cycle while s_tready is high; every
// character is folded into the running field state by one pass of logic. the
// character flagged by tlast closes the sentence: its snapshot enters a seven-stage
// conversion pipeline (reciprocal divides by 100 and 60, scaling, sign) and the
// result shows on the master channel from the last stage. the running state clears
// at the accepting edge, so the next sentence can start in the following cycle.
// the pipeline stages advance independently, so bubbles collapse: s_tready falls
// only when seven finished or pending results are held while m_tready stays low.
// characters without tlast produce no transaction. synchronous rst clears the
// field state and all pipeline valid flags; results in flight are dropped.
// depends on ngga_pkg and ngga_coord
module nmea_gga_position_parser
  import ngga_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] char_code
  input  logic          s_tlast,   // end_of_message
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // [29:0] utc_thousandths, [64:30] latitude_e7,
                                   // [99:65] longitude_e7, [103:100] zero
  output logic [1:0]    m_tuser    // [0] gga_found, [1] format_error
);

  localparam int PAD_W = 104 - UTC_W - 2 * COORD_W;

  typedef struct packed {
    logic found;
    logic err;
  } ctl_t;

  // running sentence state
  logic [2:0]        hdr_prog, hdr_prog_next;
  logic              hdr_mis, hdr_mis_next;
  logic [3:0]        fidx, fidx_next;
  logic [UTC_W-1:0]  utc_acc, utc_acc_next;
  logic [UFD_W-1:0]  utc_fd, utc_fd_next;
  logic              utc_dig, utc_dig_next;
  logic              utc_dot, utc_dot_next;
  coord_acc_t        lat, lat_next;
  coord_acc_t        lon, lon_next;
  logic              lat_dir, lat_dir_next;
  logic              lat_neg, lat_neg_next;
  logic              lon_dir, lon_dir_next;
  logic              lon_neg, lon_neg_next;
  logic              err, err_next;

  logic [7:0]        c;
  logic              is_comma;
  logic [UTC_W+3:0]  utc_pv;
  logic [UTC_W-1:0]  utc_pushed;
  logic [4:0]        tokens;
  logic              found, fault, kill, lat_cerr, lon_cerr;
  coord_snap_t       lat_snap, lon_snap;
  logic              accept;

  // pipeline flow control
  logic [NUM_STG-1:0] v, rdy;
  ctl_t               ctl [NUM_STG];
  logic               utc_kill0, utc_kill1;
  logic [UTC_W-1:0]   utc_acc0;
  logic [UFD_W-1:0]   utc_fd0;
  logic [UTC_W+9:0]   utc_s1;
  logic [UTC_W-1:0]   utc_q [2:NUM_STG-1];
  logic signed [COORD_W-1:0] lat_v, lon_v;

  assign accept = s_tvalid && s_tready;
  assign c = s_tdata;
  assign is_comma = (c == CH_COMMA);

  // per-character update of the field state
  always_comb begin
    hdr_prog_next = hdr_prog;
    hdr_mis_next  = hdr_mis;
    fidx_next     = fidx;
    utc_acc_next  = utc_acc;
    utc_fd_next   = utc_fd;
    utc_dig_next  = utc_dig;
    utc_dot_next  = utc_dot;
    lat_next      = lat;
    lon_next      = lon;
    lat_dir_next  = lat_dir;
    lat_neg_next  = lat_neg;
    lon_dir_next  = lon_dir;
    lon_neg_next  = lon_neg;
    err_next      = err;

    utc_pv = (UTC_W+4)'(utc_acc) * (UTC_W+4)'(10) + (UTC_W+4)'(c[3:0]);
    utc_pushed = (utc_pv > (UTC_W+4)'(UTC_MAX)) ? UTC_MAX : utc_pv[UTC_W-1:0];

    if (is_comma) begin
      if (fidx != FIELD_MAX) fidx_next = fidx + 4'd1;
    end else begin
      unique case (fidx)
        FIELD_HDR: begin
          if ((hdr_prog < 3'(HDR_LEN)) && (c == hdr_char(hdr_prog))) begin
            hdr_prog_next = hdr_prog + 3'd1;
          end else begin
            hdr_mis_next = 1'b1;
          end
        end
        FIELD_UTC: begin
          if (is_digit(c)) begin
            if (!utc_dot) begin
              utc_acc_next = utc_pushed;
            end else if (utc_fd < UFD_W'(UTC_FRAC_DIGITS)) begin
              utc_acc_next = utc_pushed;
              utc_fd_next  = utc_fd + UFD_W'(1);
            end
            utc_dig_next = 1'b1;
          end else if ((c == CH_DOT) && !utc_dot) begin
            utc_dot_next = 1'b1;
          end else begin
            err_next = 1'b1;
          end
        end
        FIELD_LAT: begin
          lat_next = coord_step(lat, c);
          if (coord_bad(lat, c)) err_next = 1'b1;
        end
        FIELD_LAT_DIR: begin
          if (!lat_dir) begin
            lat_dir_next = 1'b1;
            lat_neg_next = (c == CH_S) || (c == CH_W);
          end else begin
            lat_neg_next = 1'b0;
          end
        end
        FIELD_LON: begin
          lon_next = coord_step(lon, c);
          if (coord_bad(lon, c)) err_next = 1'b1;
        end
        FIELD_LON_DIR: begin
          if (!lon_dir) begin
            lon_dir_next = 1'b1;
            lon_neg_next = (c == CH_S) || (c == CH_W);
          end else begin
            lon_neg_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sentence verdict and snapshot at the closing character
  always_comb begin
    tokens   = 5'(fidx_next) + 5'(!is_comma);
    found    = !hdr_mis_next && (hdr_prog_next == 3'(HDR_LEN)) && (tokens > 5'd5);
    lat_cerr = lat_next.any && (!lat_next.dot || (lat_next.icnt != ICNT_FULL));
    lon_cerr = lon_next.any && (!lon_next.dot || (lon_next.icnt != ICNT_FULL));
    fault    = found && (err_next || !utc_dig_next || lat_cerr || lon_cerr);
    kill     = !found || fault;
    lat_snap = '{kill: kill || !lat_next.any, neg: lat_neg_next, whole: lat_next.whole,
                 frac: lat_next.frac, fcnt: lat_next.fcnt};
    lon_snap = '{kill: kill || !lon_next.any, neg: lon_neg_next, whole: lon_next.whole,
                 frac: lon_next.frac, fcnt: lon_next.fcnt};
  end

  // field state registers, cleared after each sentence
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      hdr_prog <= '0;
      hdr_mis  <= 1'b0;
      fidx     <= '0;
      utc_acc  <= '0;
      utc_fd   <= '0;
      utc_dig  <= 1'b0;
      utc_dot  <= 1'b0;
      lat      <= '0;
      lon      <= '0;
      lat_dir  <= 1'b0;
      lat_neg  <= 1'b0;
      lon_dir  <= 1'b0;
      lon_neg  <= 1'b0;
      err      <= 1'b0;
    end else if (accept) begin
      hdr_prog <= hdr_prog_next;
      hdr_mis  <= hdr_mis_next;
      fidx     <= fidx_next;
      utc_acc  <= utc_acc_next;
      utc_fd   <= utc_fd_next;
      utc_dig  <= utc_dig_next;
      utc_dot  <= utc_dot_next;
      lat      <= lat_next;
      lon      <= lon_next;
      lat_dir  <= lat_dir_next;
      lat_neg  <= lat_neg_next;
      lon_dir  <= lon_dir_next;
      lon_neg  <= lon_neg_next;
      err      <= err_next;
    end
  end

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    rdy[NUM_STG-1] = !v[NUM_STG-1] || m_tready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= s_tvalid && s_tlast;
      for (int i = 1; i < NUM_STG; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // status flags and utc scaling pipeline
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctl[0]    <= '{found: found, err: fault};
      utc_kill0 <= kill;
      utc_acc0  <= utc_acc_next;
      utc_fd0   <= utc_fd_next;
    end
    if (rdy[1]) begin
      ctl[1]    <= ctl[0];
      utc_kill1 <= utc_kill0;
      utc_s1    <= (UTC_W+10)'(utc_acc0) * (UTC_W+10)'(utc_scale(utc_fd0));
    end
    if (rdy[2]) begin
      ctl[2] <= ctl[1];
      if (utc_kill1) begin
        utc_q[2] <= '0;
      end else if (utc_s1 > (UTC_W+10)'(UTC_MAX)) begin
        utc_q[2] <= UTC_MAX;
      end else begin
        utc_q[2] <= utc_s1[UTC_W-1:0];
      end
    end
    for (int i = 3; i < NUM_STG; i++) begin
      if (rdy[i]) begin
        ctl[i]   <= ctl[i-1];
        utc_q[i] <= utc_q[i-1];
      end
    end
  end

  // coordinate conversion pipelines
  ngga_coord u_lat (
    .clk   (clk),
    .en    (rdy),
    .snap  (lat_snap),
    .value (lat_v)
  );

  ngga_coord u_lon (
    .clk   (clk),
    .en    (rdy),
    .snap  (lon_snap),
    .value (lon_v)
  );

  // result transaction
  assign m_tvalid = v[NUM_STG-1];
  assign m_tdata  = {PAD_W'(0), lon_v, lat_v, utc_q[NUM_STG-1]};
  assign m_tuser  = {ctl[NUM_STG-1].err, ctl[NUM_STG-1].found};

endmodule
